@@ rtl/complex_rect_polar_convert_macros.svh @@
// Assertion macros for the complex rectangular/polar converter.
// Used by the checker module; needs nothing else.
`ifndef COMPLEX_RECT_POLAR_CONVERT_MACROS_SVH
`define COMPLEX_RECT_POLAR_CONVERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define CRPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define CRPC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ rtl/crpc_pkg.sv @@
// Shared constants and types for the rectangular/polar converter.
// Holds the CORDIC angle table (Q60), gain constant and the flag struct.
`timescale 1ns / 1ps

package crpc_pkg;

  localparam int GUARD    = 8;
  localparam int ANG_FRAC = 60;
  localparam int ZW       = 64;
  localparam int GAIN_LAT = 5;

  // Inverse CORDIC gain, Q31.
  localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

  typedef struct packed {
    logic polar;
    logic zero;
  } crpc_flags_t;

  // Restoring division, evaluated at elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/k) in Q60 by its power series, truncating each term.
  function automatic logic [63:0] atan_recip(input logic [63:0] k);
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] n;
    logic [63:0] t;
    logic [63:0] k2;
    p  = udiv64(64'd1 << ANG_FRAC, k);
    s  = p;
    n  = 64'd1;
    k2 = k * k;
    if (k < (64'd1 << 30)) begin
      for (int j = 0; j < 64; j++) begin
        if (p != '0) begin
          p = udiv64(p, k2);
          t = udiv64(p, (n << 1) + 64'd1);
          if (n[0]) s = s - t;
          else s = s + t;
          n = n + 64'd1;
        end
      end
    end
    return s;
  endfunction

  // Entry 0 is pi/4 built from atan(1/2) + atan(1/3).
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] r;
    if (i == 0) r = atan_recip(64'd2) + atan_recip(64'd3);
    else r = atan_recip(64'd1 << i);
    return r;
  endfunction

  localparam logic [63:0] QUARTER_PI = atan_entry(0);
  localparam logic [63:0] HALF_PI    = QUARTER_PI << 1;
  localparam logic [63:0] PI_Q60     = QUARTER_PI << 2;

endpackage

@@ rtl/crpc_fifo.sv @@
// Small flip-flop queue with push/full and pop/empty sides.
// Standalone; used between the front and back parts and at the output.
`timescale 1ns / 1ps

module crpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + (AW+1)'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - (AW+1)'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

@@ rtl/crpc_front.sv @@
// Front part: classifies a request and folds it into the CORDIC range.
// Uses crpc_pkg for the guard width and the pi constants.
`timescale 1ns / 1ps

module crpc_front #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16,
  parameter int XW            = DATA_WIDTH + crpc_pkg::GUARD + 3
) (
  input  logic                          func_i,
  input  logic signed [DATA_WIDTH-1:0]  first_i,
  input  logic signed [DATA_WIDTH-1:0]  second_i,
  output crpc_pkg::crpc_flags_t         flags_o,
  output logic signed [XW-1:0]          x_o,
  output logic signed [XW-1:0]          y_o,
  output logic signed [crpc_pkg::ZW-1:0] z_o
);

  localparam int ZW  = crpc_pkg::ZW;
  localparam int ASH = crpc_pkg::ANG_FRAC - FRACTION_BITS;
  localparam logic signed [ZW-1:0] PI_FIX =
    signed'((crpc_pkg::PI_Q60 + (64'd1 << (ASH - 1))) >> ASH);
  localparam logic signed [ZW-1:0] HALF_ANG = signed'(crpc_pkg::HALF_PI >> ASH);
  localparam logic signed [ZW-1:0] HALF_Z   = signed'(crpc_pkg::HALF_PI);

  logic signed [XW-1:0] a_s, b_s, xa, yb;
  logic signed [ZW-1:0] ang_w, ang_c, z_c;

  assign a_s   = XW'(first_i);
  assign b_s   = XW'(second_i);
  assign xa    = a_s <<< crpc_pkg::GUARD;
  assign yb    = b_s <<< crpc_pkg::GUARD;
  assign ang_w = ZW'(second_i);

  always_comb begin
    flags_o.polar = ~func_i;
    flags_o.zero  = ~func_i & (first_i == '0) & (second_i == '0);

    // Saturate the angle to +-pi before scaling to Q60.
    ang_c = ang_w;
    if (ang_w > PI_FIX) ang_c = PI_FIX;
    else if (ang_w < -PI_FIX) ang_c = -PI_FIX;
    z_c = ang_c <<< ASH;

    x_o = xa;
    y_o = yb;
    z_o = '0;
    if (!func_i) begin
      // Rotate left half plane vectors by a quarter turn.
      if (xa < 0) begin
        if (yb >= 0) begin
          x_o = yb;
          y_o = -xa;
          z_o = HALF_Z;
        end else begin
          x_o = -yb;
          y_o = xa;
          z_o = -HALF_Z;
        end
      end
    end else begin
      y_o = '0;
      z_o = z_c;
      if (ang_w > HALF_ANG) begin
        x_o = '0;
        y_o = xa;
        z_o = z_c - HALF_Z;
      end else if (ang_w < -HALF_ANG) begin
        x_o = '0;
        y_o = -xa;
        z_o = z_c + HALF_Z;
      end
    end
  end

endmodule

@@ rtl/crpc_gain.sv @@
// Gain removal lane: multiply by the inverse CORDIC gain, drop guard bits,
// saturate. Five register stages; uses crpc_pkg for gain and guard width.
`timescale 1ns / 1ps

module crpc_gain #(
  parameter int IN_W  = 43,
  parameter int OUT_W = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [IN_W-1:0]  val_i,
  output logic signed [OUT_W-1:0] res_o
);

  localparam int GUARD = crpc_pkg::GUARD;
  localparam int UW    = (IN_W > 32) ? IN_W : 32;
  localparam logic signed [UW:0] MAXV = (UW+1)'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [UW:0] MINV = -MAXV - (UW+1)'(1);
  localparam logic signed [UW:0] RND  = (UW+1)'(64'sd1 <<< (GUARD - 1));

  logic [IN_W-1:0]    mag;
  logic               neg1_q, neg2_q, neg3_q;
  logic [UW-1:0]      u_q, hp_q, r_q;
  logic [61:0]        lp_q;
  logic signed [UW:0] s_q, t_w;
  logic signed [OUT_W-1:0] res_q;

  assign mag = val_i[IN_W-1] ? unsigned'(-val_i) : unsigned'(val_i);
  assign t_w = (s_q + RND) >>> GUARD;
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= val_i[IN_W-1];
      u_q    <= UW'(mag);
      neg2_q <= neg1_q;
      hp_q   <= u_q[UW-1:31] * UW'(crpc_pkg::GAIN_Q31);
      lp_q   <= 62'(u_q[30:0]) * 62'(crpc_pkg::GAIN_Q31);
      neg3_q <= neg2_q;
      r_q    <= hp_q + UW'((lp_q + (62'd1 << 30)) >> 31);
      s_q    <= neg3_q ? -signed'({1'b0, r_q}) : signed'({1'b0, r_q});
      if (t_w > MAXV) res_q <= OUT_W'(MAXV);
      else if (t_w < MINV) res_q <= OUT_W'(MINV);
      else res_q <= OUT_W'(t_w);
    end
  end

endmodule

@@ rtl/crpc_back.sv @@
// Back part: CORDIC pipeline, one stage per iteration, then gain removal
// and angle rounding. Uses crpc_pkg and crpc_gain.
`timescale 1ns / 1ps

module crpc_back #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16,
  parameter int XW            = DATA_WIDTH + crpc_pkg::GUARD + 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           in_valid_i,
  input  crpc_pkg::crpc_flags_t          in_flags_i,
  input  logic signed [XW-1:0]           in_x_i,
  input  logic signed [XW-1:0]           in_y_i,
  input  logic signed [crpc_pkg::ZW-1:0] in_z_i,
  output logic                           out_valid_o,
  output logic signed [DATA_WIDTH-1:0]   first_o,
  output logic signed [DATA_WIDTH-1:0]   second_o
);

  localparam int ZW    = crpc_pkg::ZW;
  localparam int GL    = crpc_pkg::GAIN_LAT;
  localparam int ITERS = DATA_WIDTH + 2;
  localparam int NS    = ITERS + GL + 1;
  localparam int ASH   = crpc_pkg::ANG_FRAC - FRACTION_BITS;
  localparam logic signed [ZW-1:0] PI_FIX =
    signed'((crpc_pkg::PI_Q60 + (64'd1 << (ASH - 1))) >> ASH);
  localparam logic signed [ZW-1:0] RND  = 64'sd1 <<< (ASH - 1);
  localparam logic signed [ZW-1:0] DMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [ZW-1:0] DMIN = -DMAX - 64'sd1;

  logic [NS-1:0]                vld_q;
  crpc_pkg::crpc_flags_t        flg_q [NS];
  logic signed [XW-1:0]         x_q [ITERS+1];
  logic signed [XW-1:0]         y_q [ITERS+1];
  logic signed [ZW-1:0]         z_q [ITERS+1];
  logic signed [ZW-1:0]         rnd_q, ang_c;
  logic signed [DATA_WIDTH-1:0] ang_q [GL-1];
  logic signed [DATA_WIDTH-1:0] gx, gy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flg_q[0] <= in_flags_i;
      x_q[0]   <= in_x_i;
      y_q[0]   <= in_y_i;
      z_q[0]   <= in_z_i;
      for (int k = 1; k < NS; k++) flg_q[k] <= flg_q[k-1];
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = signed'(crpc_pkg::atan_entry(i));
    logic signed [XW-1:0] dx, dy;
    logic                 cw;

    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    // Vectoring drives y to zero, rotation drives z to zero.
    assign cw = flg_q[i].polar ? (y_q[i] > 0) : z_q[i][ZW-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cw) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN_I;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN_I;
        end
      end
    end
  end

  crpc_gain #(.IN_W(XW), .OUT_W(DATA_WIDTH)) u_gain_x (
    .clk_i (clk_i),
    .en_i  (en_i),
    .val_i (x_q[ITERS]),
    .res_o (gx)
  );

  crpc_gain #(.IN_W(XW), .OUT_W(DATA_WIDTH)) u_gain_y (
    .clk_i (clk_i),
    .en_i  (en_i),
    .val_i (y_q[ITERS]),
    .res_o (gy)
  );

  always_comb begin
    ang_c = rnd_q;
    if (rnd_q > PI_FIX) ang_c = PI_FIX;
    else if (rnd_q < -PI_FIX) ang_c = -PI_FIX;
    if (ang_c > DMAX) ang_c = DMAX;
    else if (ang_c < DMIN) ang_c = DMIN;
  end

  // Angle lane: round to the output fraction, clamp, then delay to match gain.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q    <= (z_q[ITERS] + RND) >>> ASH;
      ang_q[0] <= DATA_WIDTH'(ang_c);
      for (int k = 1; k < GL - 1; k++) ang_q[k] <= ang_q[k-1];
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign first_o     = gx;
  assign second_o    = flg_q[NS-1].polar ? (flg_q[NS-1].zero ? '0 : ang_q[GL-2]) : gy;

endmodule

@@ rtl/complex_rect_polar_convert.sv @@
// Channel   Handshake        Payload
// input     push / full      func_i, first_in_i, second_in_i
// result    empty / pop      first_out_o, second_out_o
//
// One request per cycle is accepted while the input queue has room; each
// gives one result after the DATA_WIDTH+2 stage CORDIC pipeline and the
// five-stage gain removal. A stalled result queue halts the CORDIC
// pipeline; the two-entry front queue absorbs requests meanwhile.
// Reset clears only control state; there is no clearing pass.
// Top level; uses crpc_pkg, crpc_front, crpc_fifo, crpc_back.
`timescale 1ns / 1ps

module complex_rect_polar_convert #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         func_i,
  input  logic signed [DATA_WIDTH-1:0] first_in_i,
  input  logic signed [DATA_WIDTH-1:0] second_in_i,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [DATA_WIDTH-1:0] first_out_o,
  output logic signed [DATA_WIDTH-1:0] second_out_o
);

  localparam int XW = DATA_WIDTH + crpc_pkg::GUARD + 3;
  localparam int ZW = crpc_pkg::ZW;
  localparam int FW = $bits(crpc_pkg::crpc_flags_t);
  localparam int MW = FW + 2 * XW + ZW;
  localparam int OW = 2 * DATA_WIDTH;

  crpc_pkg::crpc_flags_t        cls_flags, mid_flags;
  logic signed [XW-1:0]         cls_x, cls_y, mid_x, mid_y;
  logic signed [ZW-1:0]         cls_z, mid_z;
  logic [MW-1:0]                mid_rdata;
  logic                         mid_empty;
  logic                         out_full, back_en, back_valid;
  logic signed [DATA_WIDTH-1:0] back_first, back_second;
  logic [OW-1:0]                out_rdata;

  crpc_front #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .XW            (XW)
  ) u_front (
    .func_i   (func_i),
    .first_i  (first_in_i),
    .second_i (second_in_i),
    .flags_o  (cls_flags),
    .x_o      (cls_x),
    .y_o      (cls_y),
    .z_o      (cls_z)
  );

  crpc_fifo #(.WIDTH(MW), .DEPTH(2)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({cls_flags, cls_x, cls_y, cls_z}),
    .full_o  (full),
    .pop_i   (back_en),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign {mid_flags, mid_x, mid_y, mid_z} = mid_rdata;

  // Advance the whole back pipeline only while the result queue has room.
  assign back_en = ~out_full;

  crpc_back #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .XW            (XW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (back_en),
    .in_valid_i  (~mid_empty),
    .in_flags_i  (mid_flags),
    .in_x_i      (mid_x),
    .in_y_i      (mid_y),
    .in_z_i      (mid_z),
    .out_valid_o (back_valid),
    .first_o     (back_first),
    .second_o    (back_second)
  );

  crpc_fifo #(.WIDTH(OW), .DEPTH(2)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid & back_en),
    .wdata_i ({back_first, back_second}),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign first_out_o  = out_rdata[OW-1:DATA_WIDTH];
  assign second_out_o = out_rdata[DATA_WIDTH-1:0];

endmodule

@@ rtl/crpc_checker.sv @@
// Port-level checks for the rectangular/polar converter, bound to the top.
// Depends on complex_rect_polar_convert_macros.svh.
`timescale 1ns / 1ps
`include "complex_rect_polar_convert_macros.svh"

module crpc_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic signed [DATA_WIDTH-1:0] first_out_o,
  input logic signed [DATA_WIDTH-1:0] second_out_o
);

  `CRPC_ASSERT(a_out_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(first_out_o) && $stable(second_out_o), "result changed while stalled")

  // Check in the next cycle, so the queues have been clocked in reset.
  `CRPC_ASSERT_NR(a_rst_idle, clk_i, !rst_ni |=> empty && !full, "queues not idle in reset")

  `CRPC_ASSERT(a_full_rise, clk_i, rst_ni, $rose(full) |-> $past(push) && !$past(full), "full rose without an accepted request")

endmodule

bind complex_rect_polar_convert crpc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_crpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .first_out_o  (first_out_o),
  .second_out_o (second_out_o)
);

@@ verif/complex_rect_polar_convert_test.sv @@
// Testbench for complex_rect_polar_convert: random and directed conversions in both modes,
// checked against a bit-exact CORDIC predictor kept in this file.
// Depends only on the converter RTL; no package items are needed at the ports.
`timescale 1ns / 1ps

module complex_rect_polar_convert_test;

  localparam int DW        = 32;
  localparam int FB        = 16;
  localparam int GUARD_B   = 8;
  localparam int ANGLE_FB  = 60;
  localparam int STEPS     = DW + 2;
  localparam longint unsigned INV_GAIN = 64'd1304065748;
  localparam int MAX_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic signed [DW-1:0] PI_Q16 = 32'sd205887;

  localparam bit TO_POLAR = 1'b0;
  localparam bit TO_RECT  = 1'b1;

  typedef struct {
    bit                   fn;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
  } conv_req_t;

  typedef struct {
    logic signed [DW-1:0] first;
    logic signed [DW-1:0] second;
  } conv_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic                 func_i = 1'b0;
  logic signed [DW-1:0] first_in_i = '0;
  logic signed [DW-1:0] second_in_i = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic signed [DW-1:0] first_out_o;
  logic signed [DW-1:0] second_out_o;

  conv_req_t pending_reqs[$];
  conv_res_t expected_results[$];
  longint    angle_step_q60[64];
  longint    pi_q60;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        send_gap = 0;
  int        recv_gap = 0;

  complex_rect_polar_convert u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .first_in_i  (first_in_i),
    .second_in_i (second_in_i),
    .empty       (empty),
    .pop         (pop),
    .first_out_o (first_out_o),
    .second_out_o(second_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // atan(1/k) in Q60 by the alternating power series
  function automatic longint unsigned arctan_recip(input longint unsigned k);
    longint unsigned p, s, n, t, k2;
    p = (64'd1 << ANGLE_FB) / k;
    s = p;
    n = 1;
    if (k < (64'd1 << 30)) begin
      k2 = k * k;
      while (p != 0) begin
        p = p / k2;
        t = p / (2 * n + 1);
        if (n[0]) s = s - t;
        else s = s + t;
        n++;
      end
    end
    return s;
  endfunction

  function automatic longint round_shr(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  // Remove the CORDIC gain, rounding half away from zero.
  function automatic longint remove_gain(input longint v);
    longint unsigned u, r;
    u = (v < 0) ? longint'(-v) : v;
    r = (u >> 31) * INV_GAIN + (((u & 64'h7FFF_FFFF) * INV_GAIN + (64'd1 << 30)) >> 31);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [DW-1:0] saturate(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[DW-1:0];
  endfunction

  function automatic conv_res_t predict_conversion(input conv_req_t rq);
    conv_res_t res;
    longint a, b, x, y, z, t, dx, dy, pf, ang;
    a  = rq.a;
    b  = rq.b;
    pf = round_shr(pi_q60, ANGLE_FB - FB);
    if (rq.fn == TO_POLAR) begin
      if (a == 0 && b == 0) begin
        res.first  = '0;
        res.second = '0;
        return res;
      end
      x = a <<< GUARD_B;
      y = b <<< GUARD_B;
      z = 0;
      // fold the left half plane into the right one
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = pi_q60 / 2;
        end else begin
          t = x; x = -y; y = t; z = -(pi_q60 / 2);
        end
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += angle_step_q60[i];
        end else begin
          x -= dx; y += dy; z -= angle_step_q60[i];
        end
      end
      ang = round_shr(z, ANGLE_FB - FB);
      if (ang > pf) ang = pf;
      if (ang < -pf) ang = -pf;
      res.first  = saturate(round_shr(remove_gain(x), GUARD_B));
      res.second = saturate(ang);
    end else begin
      if (b > pf) b = pf;
      if (b < -pf) b = -pf;
      z = b <<< (ANGLE_FB - FB);
      x = a <<< GUARD_B;
      y = 0;
      if (z > pi_q60 / 2) begin
        y = x; x = 0; z -= pi_q60 / 2;
      end else if (z < -(pi_q60 / 2)) begin
        y = -x; x = 0; z += pi_q60 / 2;
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= angle_step_q60[i];
        end else begin
          x += dx; y -= dy; z += angle_step_q60[i];
        end
      end
      res.first  = saturate(round_shr(remove_gain(x), GUARD_B));
      res.second = saturate(round_shr(remove_gain(y), GUARD_B));
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones, often none.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [DW-1:0] scaled_value();
    logic signed [DW-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 3) != 0) v = v >>> $urandom_range(0, 31);
    return v;
  endfunction

  task automatic queue_req(input bit fn, input logic signed [DW-1:0] a,
                           input logic signed [DW-1:0] b);
    conv_req_t rq;
    rq.fn = fn;
    rq.a  = a;
    rq.b  = b;
    pending_reqs.push_back(rq);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || push || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: advance to the next request once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        expected_results.push_back(predict_conversion(pending_reqs.pop_front()));
        send_gap = draw_gap();
      end else if (!push && send_gap > 0) begin
        send_gap--;
      end
      if (pending_reqs.size() != 0 && send_gap == 0) begin
        push        <= 1'b1;
        func_i      <= pending_reqs[0].fn;
        first_in_i  <= pending_reqs[0].a;
        second_in_i <= pending_reqs[0].b;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check each popped result against the oldest expectation.
  always @(posedge clk_i) begin
    conv_res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: first_out %0d second_out %0d", first_out_o, second_out_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (first_out_o !== want.first) begin
            $error("first_out: expected %0d, got %0d", want.first, first_out_o);
            fail_count++;
          end
          if (second_out_o !== want.second) begin
            $error("second_out: expected %0d, got %0d", want.second, second_out_o);
            fail_count++;
          end
        end
        recv_gap = draw_gap();
      end else if (!pop && recv_gap > 0) begin
        recv_gap--;
      end
      pop <= (recv_gap == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic signed [DW-1:0] a, b;
    angle_step_q60[0] = arctan_recip(2) + arctan_recip(3);
    for (int i = 1; i < 64; i++) angle_step_q60[i] = arctan_recip(64'd1 << i);
    pi_q60 = angle_step_q60[0] * 4;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners: zero vector, the axes, negative real axis, full-scale values, and angles of 0, +-pi and out of range
    queue_req(TO_POLAR, 0, 0);
    queue_req(TO_POLAR, 1, 0);
    queue_req(TO_POLAR, -65536, 0);
    queue_req(TO_POLAR, 0, 65536);
    queue_req(TO_POLAR, 0, -1);
    queue_req(TO_POLAR, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_req(TO_POLAR, 32'sh8000_0000, 32'sh8000_0000);
    queue_req(TO_POLAR, 32'sh8000_0000, 0);
    queue_req(TO_POLAR, 32'sh7FFF_FFFF, -1);
    queue_req(TO_POLAR, -1, -1);
    queue_req(TO_RECT, 65536, 0);
    queue_req(TO_RECT, 65536, PI_Q16);
    queue_req(TO_RECT, 65536, -PI_Q16);
    queue_req(TO_RECT, 65536, 32'sh7FFF_FFFF);
    queue_req(TO_RECT, 65536, 32'sh8000_0000);
    queue_req(TO_RECT, -131072, 65536);
    queue_req(TO_RECT, 32'sh7FFF_FFFF, 51472);
    queue_req(TO_RECT, 32'sh8000_0000, -85197);
    queue_req(TO_RECT, 0, 65536);
    queue_req(TO_RECT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    wait_idle();

    for (int n = 0; n < 850; n++) begin
      // hold the sender now and then until every result is back
      if (n == 300 || n == 600) wait_idle();
      if ($urandom_range(0, 9) < 3) begin
        a = $urandom;
        b = $urandom;
      end else begin
        a = scaled_value();
        b = scaled_value();
      end
      if (n % 2 == 1 && $urandom_range(0, 9) != 0)
        b = $signed($urandom_range(0, 2 * 205887)) - PI_Q16;
      queue_req(n % 2 == 1, a, b);
      if (n % 40 == 0) @(posedge clk_i);
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/crpc_pkg.sv
rtl/crpc_fifo.sv
rtl/crpc_front.sv
rtl/crpc_gain.sv
rtl/crpc_back.sv
rtl/complex_rect_polar_convert.sv
rtl/crpc_checker.sv
verif/complex_rect_polar_convert_test.sv
